### hw/rtl/kmsm_pkg.sv
package kmsm_pkg;

    // geometry of the scan matrix
    localparam int NUM_LINES  = 8;
    localparam int NUM_KEYS   = 4;
    localparam int LINE_IDX_W = $clog2(NUM_LINES);
    localparam int MAP_W      = 32;
    localparam int BTN_W      = 12;

    // host button bits
    localparam int BTN_A_BIT          = 4;
    localparam int BTN_SOFT_TIME_BIT  = 10;
    localparam int BTN_SOFT_ALARM_BIT = 11;

    // d-pad direction codes
    localparam logic [3:0] DIR_LEFT  = 4'h1;
    localparam logic [3:0] DIR_UP    = 4'h2;
    localparam logic [3:0] DIR_RIGHT = 4'h4;
    localparam logic [3:0] DIR_DOWN  = 4'h8;
    localparam logic [3:0] DIR_VERT  = DIR_UP | DIR_DOWN;
    localparam logic [3:0] DIR_HORIZ = DIR_LEFT | DIR_RIGHT;

    // diagonal codes that mark a d-pad line
    localparam logic [7:0] DIAG_UL = 8'h03;
    localparam logic [7:0] DIAG_DL = 8'h09;
    localparam logic [7:0] DIAG_UR = 8'h06;
    localparam logic [7:0] DIAG_DR = 8'h0C;

    // soft key codes
    localparam logic [7:0] SOFT_NONE  = 8'h00;
    localparam logic [7:0] SOFT_TIME  = 8'h60;
    localparam logic [7:0] SOFT_ALARM = 8'hA0;

    // an idle strobe scans line 1
    localparam logic [NUM_LINES-1:0] STROBE_DEFAULT = 8'h02;

    // working value handed from one scan line to the next
    typedef struct packed {
        logic [7:0] keys;
        logic [3:0] last_dpad;
        logic       held;
    } kmsm_chain_t;

endpackage

### hw/rtl/kmsm_line.sv
module kmsm_line
    import kmsm_pkg::*;
(
    input  logic [MAP_W-1:0]    map_word,
    input  logic                sel,
    input  logic [7:0]          soft_code,
    input  logic                pressed,
    input  kmsm_chain_t         chain_in,
    output kmsm_chain_t         chain_out,
    output logic [NUM_KEYS-1:0] k_bits
);

    logic [7:0]          code [NUM_KEYS];
    logic                is_dpad;
    logic [3:0]          dkeys;
    logic                dheld;
    logic [NUM_KEYS-1:0] dmatch;

    // split the map word into its button-code bytes
    always_comb
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            code[k] = map_word[8*k +: 8];
        end
    end

    // a d-pad line holds all four diagonals somewhere in its bytes
    always_comb
    begin
        logic f_ul, f_dl, f_ur, f_dr;
        f_ul = 1'b0;
        f_dl = 1'b0;
        f_ur = 1'b0;
        f_dr = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            f_ul = f_ul | (code[k] == DIAG_UL);
            f_dl = f_dl | (code[k] == DIAG_DL);
            f_ur = f_ur | (code[k] == DIAG_UR);
            f_dr = f_dr | (code[k] == DIAG_DR);
        end
        is_dpad = f_ul & f_dl & f_ur & f_dr;
    end

    // d-pad rewrite: shortcut diagonal, then perpendicular axis fill-in
    always_comb
    begin
        logic [3:0] v;
        v     = chain_in.keys[3:0];
        dheld = chain_in.held;
        if (pressed && !chain_in.held)
        begin
            dheld = 1'b1;
            v     = ~chain_in.last_dpad;
        end
        unique case (v)
            DIR_LEFT:  dkeys = (chain_in.last_dpad & DIR_VERT) | DIR_LEFT;
            DIR_RIGHT: dkeys = (chain_in.last_dpad & DIR_VERT) | DIR_RIGHT;
            DIR_DOWN:  dkeys = (chain_in.last_dpad & DIR_HORIZ) | DIR_DOWN;
            DIR_UP:    dkeys = (chain_in.last_dpad & DIR_HORIZ) | DIR_UP;
            default:   dkeys = v;
        endcase
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            dmatch[k] = (code[k] == {4'h0, dkeys});
        end
    end

    // per-line match and chain update
    always_comb
    begin
        chain_out = chain_in;
        k_bits    = '0;
        if (sel)
        begin
            if (is_dpad)
            begin
                k_bits         = dmatch;
                chain_out.keys = {4'h0, dkeys};
                chain_out.held = dheld;
                if (|dmatch)
                begin
                    chain_out.last_dpad = dkeys;
                end
            end
            else if (soft_code != SOFT_NONE)
            begin
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    k_bits[k] = (code[k] == soft_code);
                end
            end
            else
            begin
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    k_bits[k] = (|(code[k] & chain_in.keys))
                              && (code[k] != SOFT_ALARM) && (code[k] != SOFT_TIME);
                end
            end
        end
    end

endmodule

### hw/rtl/key_matrix_scan_mapper_core.sv
// channel | signals                          | beat
// --------+----------------------------------+------------------------------
// in      | in_valid, in_stall               | strobe_req, buttons
// out     | out_valid, out_stall             | k_lines
// cfg     | cfg_write_en, cfg_index          | cfg_data (map word of a line)
//
// one beat per cycle while out_stall is low; an accepted input beat passes
// through the input register, then the eight-line match chain into the
// result register, which also updates the d-pad and shortcut state.
// rst_n is asynchronous, active low; it clears map words, state and valids.
// a stalled result holds in the output register while one more input beat
// is taken into the input register; further beats stall until it drains.
module key_matrix_scan_mapper_core
    import kmsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [NUM_LINES-1:0]  strobe_req,
    input  logic [BTN_W-1:0]      buttons,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [NUM_KEYS-1:0]   k_lines,
    input  logic                  cfg_write_en,
    input  logic [LINE_IDX_W-1:0] cfg_index,
    input  logic [MAP_W-1:0]      cfg_data
);

    logic [MAP_W-1:0]     map_reg [NUM_LINES];
    logic                 in_valid_reg, in_valid_next;
    logic [NUM_LINES-1:0] strobe_reg;
    logic [BTN_W-1:0]     buttons_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [NUM_KEYS-1:0]  k_lines_reg, k_lines_next;
    logic [3:0]           last_dpad_reg, last_dpad_next;
    logic                 pressed_reg, pressed_next;
    logic                 held_reg, held_next;

    logic                 accept;
    logic                 advance;
    logic [7:0]           keys;
    logic [7:0]           soft_code;
    logic                 held_pre;
    logic                 active;
    logic [NUM_LINES-1:0] strobe_eff;
    kmsm_chain_t          chain [NUM_LINES+1];
    logic [NUM_KEYS-1:0]  k_part [NUM_LINES];

    // handshake
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // map words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LINES; i++)
            begin
                map_reg[i] <= '0;
            end
        end
        else if (cfg_write_en)
        begin
            map_reg[cfg_index] <= cfg_data;
        end
    end

    // soft key decode
    always_comb
    begin
        keys      = buttons_reg[7:0];
        soft_code = SOFT_NONE;
        if (buttons_reg[BTN_SOFT_TIME_BIT])
        begin
            keys      = 8'h00;
            soft_code = SOFT_TIME;
        end
        if (buttons_reg[BTN_SOFT_ALARM_BIT])
        begin
            keys      = 8'h00;
            soft_code = SOFT_ALARM;
        end
        if (keys == SOFT_ALARM)
        begin
            soft_code = SOFT_ALARM;
            keys      = 8'h00;
        end
        if (keys == SOFT_TIME)
        begin
            soft_code = SOFT_TIME;
            keys      = 8'h00;
        end
    end

    // shortcut tracking, then the idle check
    assign pressed_next = keys[BTN_A_BIT];
    assign held_pre     = keys[BTN_A_BIT] ? held_reg : 1'b0;
    assign active       = (keys != 8'h00) || (soft_code != SOFT_NONE);
    assign strobe_eff   = (strobe_reg == '0) ? STROBE_DEFAULT : strobe_reg;

    assign chain[0] = '{keys: keys, last_dpad: last_dpad_reg, held: held_pre};

    // scan lines in ascending order
    for (genvar g = 0; g < NUM_LINES; g++)
    begin : g_line
        kmsm_line u_line (
            .map_word  (map_reg[g]),
            .sel       (strobe_eff[g] & active),
            .soft_code (soft_code),
            .pressed   (pressed_next),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .k_bits    (k_part[g])
        );
    end

    // merge line results
    always_comb
    begin
        k_lines_next = '0;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            k_lines_next = k_lines_next | k_part[i];
        end
    end

    assign last_dpad_next = chain[NUM_LINES].last_dpad;
    assign held_next      = chain[NUM_LINES].held;

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_dpad_reg <= '0;
            pressed_reg   <= 1'b0;
            held_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                last_dpad_reg <= last_dpad_next;
                pressed_reg   <= pressed_next;
                held_reg      <= held_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            strobe_reg  <= strobe_req;
            buttons_reg <= buttons;
        end
        if (advance)
        begin
            k_lines_reg <= k_lines_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign k_lines   = k_lines_reg;

`ifndef SYNTHESIS
    // a held shortcut always belongs to a pressed A
    a_held_needs_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> pressed_reg)
        else $error("shortcut held without A pressed");

    // input side only waits on a blocked output register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without output backpressure");

    // idle buttons give an all-low result
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !active) |=> (k_lines == '0))
        else $error("idle beat produced active k lines");

    // state moves only with a completed beat
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(last_dpad_reg) && $stable(held_reg)))
        else $error("d-pad state changed without a beat");
`endif

endmodule
